>>> design/dram_row_buffer_access_timing_macros.svh
// ---------------------------------------------------------------------------
// DRAM row buffer timing - assertion macros
// Clocked on aclk, disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef DRAM_ROW_BUFFER_ACCESS_TIMING_MACROS_SVH
`define DRAM_ROW_BUFFER_ACCESS_TIMING_MACROS_SVH

// flag a condition that must never hold
`define DRBT_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

// antecedent in this cycle implies consequent in the same cycle
`define DRBT_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define DRBT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/drbt_pkg.sv
// ---------------------------------------------------------------------------
// DRAM row buffer timing - package
// Geometry, field widths, codes and the controller/datapath interface types.
// ---------------------------------------------------------------------------
package drbt_pkg;

    // geometry; both counts are powers of two
    localparam int ROW_COUNT  = 1024;
    localparam int ROW_WORDS  = 256;
    localparam int BANK_WORDS = ROW_COUNT * ROW_WORDS;

    localparam int ROW_AW      = $clog2(ROW_COUNT);
    localparam int COL_AW      = $clog2(ROW_WORDS);
    localparam int BANK_AW     = ROW_AW + COL_AW;
    localparam int BYTE_AW     = BANK_AW + 2;
    localparam int CNT_W       = $clog2(BANK_WORDS + 1);

    localparam int DATA_W      = 32;
    localparam int DELAY_W     = 10;
    localparam int LAT_W       = 12;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 2;

    localparam logic [DELAY_W-1:0] ROW_DELAY_RESET = DELAY_W'(10);
    localparam logic [DELAY_W-1:0] COL_DELAY_RESET = DELAY_W'(2);

    localparam logic [CFG_IDX_W-1:0] REG_ROW_DELAY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COL_DELAY = CFG_IDX_W'(1);

    localparam logic [KIND_W-1:0] KIND_HIT      = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_EMPTY    = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_CONFLICT = KIND_W'(2);

    localparam logic MODE_STORE = 1'b1;

    typedef struct packed {
        logic             take_item;
        logic             classify;
        logic             clear_step;
        logic             xfer_rd;
        logic             xfer_wb;
        logic             open_row;
        logic             access;
        logic             finish;
        logic [CNT_W-1:0] cnt;
    } drbt_cmd_t;

    typedef struct packed {
        logic bad;
        logic hit;
        logic row_open;
        logic out_free;
    } drbt_sts_t;

endpackage

>>> design/drbt_ram.sv
// ---------------------------------------------------------------------------
// DRAM row buffer timing - generic RAM
// One write port, one read port with read enable and registered data.
// ---------------------------------------------------------------------------
module drbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/drbt_ctrl.sv
// ---------------------------------------------------------------------------
// DRAM row buffer timing - controller
// Sequences the bank clear, row write back, row load, column access and result.
// ---------------------------------------------------------------------------
module drbt_ctrl
    import drbt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  drbt_sts_t  sts,
    output drbt_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_CHECK  = 7'b0000100,
        ST_WBACK  = 7'b0001000,
        ST_LOAD   = 7'b0010000,
        ST_ACCESS = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    localparam logic [CNT_W-1:0] CLEAR_LAST = CNT_W'(BANK_WORDS - 1);
    localparam logic [CNT_W-1:0] ROW_END    = CNT_W'(ROW_WORDS);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.cnt    = cnt_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (cnt_reg == CLEAR_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take_item = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.classify = 1'b1;
                cnt_next     = '0;
                if (sts.bad) begin
                    state_next = ST_DONE;
                end else if (sts.hit) begin
                    state_next = ST_ACCESS;
                end else if (sts.row_open) begin
                    state_next = ST_WBACK;
                end else begin
                    state_next = ST_LOAD;
                end
            end
            ST_WBACK: begin
                cmd.xfer_wb = 1'b1;
                cmd.xfer_rd = (cnt_reg != ROW_END);
                if (cnt_reg == ROW_END) begin
                    cnt_next   = '0;
                    state_next = ST_LOAD;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_LOAD: begin
                cmd.xfer_rd = (cnt_reg != ROW_END);
                if (cnt_reg == ROW_END) begin
                    cmd.open_row = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_ACCESS;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_ACCESS: begin
                cmd.access = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> design/drbt_dpath.sv
// ---------------------------------------------------------------------------
// DRAM row buffer timing - datapath
// Bank memory, row buffer, open row state, update count and result register.
// ---------------------------------------------------------------------------
module drbt_dpath
    import drbt_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  drbt_cmd_t                cmd,
    output drbt_sts_t                sts,
    input  logic                     s_mode,
    input  logic signed [DATA_W-1:0] s_address,
    input  logic signed [DATA_W-1:0] s_write_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_read_data,
    output logic [LAT_W-1:0]         m_latency,
    output logic [KIND_W-1:0]        m_access_kind,
    output logic                     m_bad_address,
    output logic [DATA_W-1:0]        m_update_count,
    input  logic                     cfg_valid,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data
);

    logic [DELAY_W-1:0] row_delay_reg, col_delay_reg;

    logic              item_mode_reg;
    logic [DATA_W-1:0] item_addr_reg;
    logic [DATA_W-1:0] item_wdata_reg;

    logic [ROW_AW-1:0] open_row_reg;
    logic              row_open_reg;
    logic [DATA_W-1:0] updates_reg;

    logic              xfer_wr_reg, xfer_dir_reg;
    logic [COL_AW-1:0] xfer_idx_reg;

    logic              bad_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [LAT_W-1:0]  lat_reg;

    logic              m_valid_reg;
    logic [DATA_W-1:0] m_read_data_reg;
    logic [LAT_W-1:0]  m_latency_reg;
    logic [KIND_W-1:0] m_kind_reg;
    logic              m_bad_reg;
    logic [DATA_W-1:0] m_count_reg;

    logic [ROW_AW-1:0] item_row;
    logic [COL_AW-1:0] item_col;
    logic [COL_AW-1:0] step_idx;
    logic              addr_bad, row_hit, bump;
    logic              is_store;

    logic               bank_we, bank_re;
    logic [BANK_AW-1:0] bank_waddr, bank_raddr;
    logic [DATA_W-1:0]  bank_wdata, bank_rdata;

    logic               rb_we, rb_re;
    logic [COL_AW-1:0]  rb_waddr, rb_raddr;
    logic [DATA_W-1:0]  rb_wdata, rb_rdata;

    logic [LAT_W-1:0] lat_hit, lat_empty, lat_conflict;

    assign item_row = item_addr_reg[2 + COL_AW +: ROW_AW];
    assign item_col = item_addr_reg[2 +: COL_AW];
    assign step_idx = cmd.cnt[COL_AW-1:0];
    assign is_store = (item_mode_reg == MODE_STORE);

    assign addr_bad = (item_addr_reg[1:0] != 2'b00) ||
                      (item_addr_reg[DATA_W-1:BYTE_AW] != '0);
    assign row_hit  = row_open_reg && (open_row_reg == item_row);

    assign sts.bad      = addr_bad;
    assign sts.hit      = row_hit;
    assign sts.row_open = row_open_reg;
    assign sts.out_free = !m_valid_reg || m_ready;

    assign lat_hit      = LAT_W'(col_delay_reg);
    assign lat_empty    = LAT_W'(row_delay_reg) + LAT_W'(col_delay_reg);
    assign lat_conflict = LAT_W'({row_delay_reg, 1'b0}) + LAT_W'(col_delay_reg);

    // bank: cleared after reset, written back from the row buffer, read on row load
    assign bank_we    = cmd.clear_step || (xfer_wr_reg && xfer_dir_reg);
    assign bank_waddr = cmd.clear_step ? cmd.cnt[BANK_AW-1:0] : {open_row_reg, xfer_idx_reg};
    assign bank_wdata = cmd.clear_step ? '0 : rb_rdata;
    assign bank_re    = cmd.xfer_rd && !cmd.xfer_wb;
    assign bank_raddr = {item_row, step_idx};

    // row buffer: filled on row load, written on store, read on write back and access
    assign rb_we    = (xfer_wr_reg && !xfer_dir_reg) || (cmd.access && is_store);
    assign rb_waddr = cmd.access ? item_col : xfer_idx_reg;
    assign rb_wdata = cmd.access ? item_wdata_reg : bank_rdata;
    assign rb_re    = cmd.access || (cmd.xfer_rd && cmd.xfer_wb);
    assign rb_raddr = cmd.access ? item_col : step_idx;

    assign bump = cmd.open_row || (cmd.access && is_store);

    drbt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BANK_WORDS)
    ) u_bank (
        .aclk  (aclk),
        .we    (bank_we),
        .waddr (bank_waddr),
        .wdata (bank_wdata),
        .re    (bank_re),
        .raddr (bank_raddr),
        .rdata (bank_rdata)
    );

    drbt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ROW_WORDS)
    ) u_row_buf (
        .aclk  (aclk),
        .we    (rb_we),
        .waddr (rb_waddr),
        .wdata (rb_wdata),
        .re    (rb_re),
        .raddr (rb_raddr),
        .rdata (rb_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_delay_reg <= ROW_DELAY_RESET;
            col_delay_reg <= COL_DELAY_RESET;
            open_row_reg  <= '0;
            row_open_reg  <= 1'b0;
            updates_reg   <= '0;
            xfer_wr_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_ROW_DELAY: row_delay_reg <= cfg_data[DELAY_W-1:0];
                    REG_COL_DELAY: col_delay_reg <= cfg_data[DELAY_W-1:0];
                    default: ;
                endcase
            end
            xfer_wr_reg <= cmd.xfer_rd;
            if (cmd.open_row) begin
                open_row_reg <= item_row;
                row_open_reg <= 1'b1;
            end
            if (bump && (updates_reg != '1)) begin
                updates_reg <= updates_reg + DATA_W'(1);
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        xfer_dir_reg <= cmd.xfer_wb;
        xfer_idx_reg <= step_idx;
        if (cmd.take_item) begin
            item_mode_reg  <= s_mode;
            item_addr_reg  <= s_address;
            item_wdata_reg <= s_write_data;
        end
        if (cmd.classify) begin
            bad_reg <= addr_bad;
            if (addr_bad || row_hit) begin
                kind_reg <= KIND_HIT;
                lat_reg  <= addr_bad ? '0 : lat_hit;
            end else if (row_open_reg) begin
                kind_reg <= KIND_CONFLICT;
                lat_reg  <= lat_conflict;
            end else begin
                kind_reg <= KIND_EMPTY;
                lat_reg  <= lat_empty;
            end
        end
        if (cmd.finish) begin
            m_read_data_reg <= (bad_reg || is_store) ? '0 : rb_rdata;
            m_latency_reg   <= lat_reg;
            m_kind_reg      <= kind_reg;
            m_bad_reg       <= bad_reg;
            m_count_reg     <= updates_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_read_data    = m_read_data_reg;
    assign m_latency      = m_latency_reg;
    assign m_access_kind  = m_kind_reg;
    assign m_bad_address  = m_bad_reg;
    assign m_update_count = m_count_reg;

endmodule

>>> design/dram_row_buffer_access_timing.sv
// Path, accept to result valid: a bad address goes straight to the result, a row hit does
// the column access, no open row first loads the row, a row conflict first writes it back.
// Words are taken one at a time: the next is accepted once the result is registered; the
// row copy loop moves one word per cycle through the bank.
// Reset: synchronous, active low; the bank is then zeroed word by word, during which
// no word is accepted; configuration writes are taken.
// ---------------------------------------------------------------------------
// DRAM row buffer timing - top level
// One DRAM bank with an open row buffer, word loads and stores with latency class.
// ---------------------------------------------------------------------------
`include "dram_row_buffer_access_timing_macros.svh"

module dram_row_buffer_access_timing
    import drbt_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_mode,
    input  logic signed [DATA_W-1:0] s_address,
    input  logic signed [DATA_W-1:0] s_write_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_read_data,
    output logic [LAT_W-1:0]         m_latency,
    output logic [KIND_W-1:0]        m_access_kind,
    output logic                     m_bad_address,
    output logic [DATA_W-1:0]        m_update_count,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data
);

    drbt_cmd_t cmd;
    drbt_sts_t sts;

    logic [5:0] cmd_strobes;
    logic       bad_word_clear;

    assign cfg_ready = 1'b1;

    drbt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    drbt_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_mode         (s_mode),
        .s_address      (s_address),
        .s_write_data   (s_write_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .m_latency      (m_latency),
        .m_access_kind  (m_access_kind),
        .m_bad_address  (m_bad_address),
        .m_update_count (m_update_count),
        .cfg_valid      (cfg_valid & cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    assign cmd_strobes    = {cmd.take_item, cmd.classify, cmd.clear_step,
                             cmd.xfer_rd, cmd.access, cmd.finish};
    assign bad_word_clear = ({m_read_data, m_latency, m_access_kind} == '0);

    `DRBT_ASSERT_IMPLY(a_bad_word_zero, m_valid && m_bad_address, bad_word_clear, "bad word not zero")
    `DRBT_ASSERT_NEVER(a_cmd_exclusive, !$onehot0(cmd_strobes), "overlapping controller commands")
    `DRBT_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "second word taken in flight")

endmodule
